FILE: hw/rtl/wamt_pkg.sv
package wamt_pkg;

	localparam int NODES       = 8;
	localparam int WEIGHT_BITS = 16;
	localparam int DEPTH       = NODES * NODES;
	localparam int ADDR_W      = $clog2(DEPTH);

	typedef enum logic [1:0] {
		OP_INS  = 2'd0,
		OP_DEL  = 2'd1,
		OP_VDEL = 2'd2,
		OP_FIND = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_NOCHG   = 2'd1,
		STAT_RANGE   = 2'd2,
		STAT_NOMATCH = 2'd3
	} status_t;

	typedef logic [WEIGHT_BITS-1:0] weight_t;
	typedef logic [ADDR_W-1:0]      addr_t;

	// keep the low WEIGHT_BITS bits of the 16-bit weight field
	function automatic weight_t mask_weight(input logic [15:0] x);
		logic [31:0] t;
		t = {16'd0, x};
		return t[WEIGHT_BITS-1:0];
	endfunction

	function automatic addr_t addr_of(input logic [2:0] r, input logic [2:0] c);
		addr_t ra;
		addr_t ca;
		ra = addr_t'(r);
		ca = addr_t'(c);
		return addr_t'(ra * addr_t'(NODES)) + ca;
	endfunction

endpackage

FILE: hw/rtl/weighted_adjacency_matrix_table.sv
// Weighted undirected adjacency matrix with an edge counter.
//
// Command channel: drive op, vertex_a, vertex_b and weight with start high;
// the command is taken at the rising edge where start is high and busy is
// low. Results come out on match_row, match_col, edge_total, status and last,
// each valid for exactly one cycle while strobe is high. The receiver cannot
// stall; every result must be taken in its strobe cycle.
// Edge insert and delete give one result: the entry read at the command edge is
// checked in S_EDGE and the result registered. An insert that stores a non-loop
// edge also passes S_WR2, a second write port access, for the mirrored entry.
// Delete vertex reads its row through the single read port and gives its result
// once the last of its v entries is read (v = vertices in use).
// Find weight reads all v * v in-use entries, one per cycle, then passes S_FLUSH
// when the last entry read matches. Results stream out while the scan runs;
// the final one carries last.
// Out-of-range commands give their result the cycle after the command.
// The user must write vertex_count over the APB port only while the block is
// idle; the block does not enforce it. Reset clears the per-entry valid flags,
// so the matrix reads as all zero at once; the edge count is zeroed and vertex_count returns to 8.
module weighted_adjacency_matrix_table
	import wamt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [2:0]  vertex_a,
	input  logic [2:0]  vertex_b,
	input  logic [15:0] weight,
	output logic        strobe,
	output logic [2:0]  match_row,
	output logic [2:0]  match_col,
	output logic [5:0]  edge_total,
	output logic [1:0]  status,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EDGE,
		S_WR2,
		S_DELV,
		S_SRCH,
		S_FLUSH
	} state_t;

	state_t            state_q;
	logic [3:0]        vcount_q;
	logic [5:0]        ecount_q;
	op_t               op_q;
	logic [2:0]        a_q;
	logic [2:0]        b_q;
	weight_t           w_q;
	logic [3:0]        v_q;
	logic [2:0]        r_q;
	logic [2:0]        c_q;
	logic              issuing_q;
	logic [3:0]        cnt_q;
	logic              pend_q;
	logic [2:0]        prow_q;
	logic [2:0]        pcol_q;

	logic              strobe_q;
	logic [2:0]        row_q;
	logic [2:0]        col_q;
	logic [5:0]        total_q;
	status_t           status_q;
	logic              last_q;

	weight_t           mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	weight_t           rdata_s1;
	logic              rvalid_s1;
	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic [2:0]        rd_row_s1;
	logic [2:0]        rd_col_s1;

	logic              accept;
	op_t               op_in;
	weight_t           w_in;
	logic [3:0]        v_in;
	logic              a_oor;
	logic              b_oor;
	logic              rd_en;
	logic [2:0]        rd_row;
	logic [2:0]        rd_col;
	logic [3:0]        rd_vmax;
	logic              col_end;
	logic              rd_last;
	addr_t             raddr;
	logic              we;
	addr_t             waddr;
	logic [DEPTH-1:0]  clr;
	weight_t           entry;
	logic              nz;
	logic              hit;
	logic [3:0]        removed;

	logic              em_en;
	logic [2:0]        em_row;
	logic [2:0]        em_col;
	logic [5:0]        em_total;
	status_t           em_status;
	logic              em_last;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign op_in  = op_t'(op);
	assign w_in   = mask_weight(weight);
	assign v_in   = (vcount_q > 4'(NODES)) ? 4'(NODES) : vcount_q;
	assign a_oor  = ({1'b0, vertex_a} >= v_in);
	assign b_oor  = ({1'b0, vertex_b} >= v_in);

	assign entry   = rvalid_s1 ? rdata_s1 : '0;
	assign nz      = (entry != '0);
	assign hit     = (entry == w_q);
	assign removed = cnt_q + 4'(nz);

	// config port
	assign pready = 1'b1;
	assign prdata = {28'd0, vcount_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 4'(NODES);
		end else if (psel && penable && pwrite) begin
			vcount_q <= pwdata[3:0];
		end
	end

	// read issue: the command edge issues the first read, scans issue one per cycle
	always_comb begin
		rd_en   = 1'b0;
		rd_row  = r_q;
		rd_col  = c_q;
		rd_vmax = v_q;
		rd_last = 1'b0;
		if (state_q == S_IDLE) begin
			rd_vmax = v_in;
			case (op_in)
				OP_FIND: begin
					rd_row = 3'd0;
					rd_col = 3'd0;
					rd_en  = accept && (v_in != 4'd0);
				end
				OP_VDEL: begin
					rd_row = vertex_a;
					rd_col = 3'd0;
					rd_en  = accept && !a_oor;
				end
				default: begin
					rd_row = vertex_a;
					rd_col = vertex_b;
					rd_en  = accept && !a_oor && !b_oor;
				end
			endcase
		end else if (state_q == S_SRCH || state_q == S_DELV) begin
			rd_row = (op_q == OP_FIND) ? r_q : a_q;
			rd_en  = issuing_q;
		end
		col_end = (({1'b0, rd_col} + 4'd1) == rd_vmax);
		if (((state_q == S_IDLE) ? op_in : op_q) == OP_FIND) begin
			rd_last = col_end && (({1'b0, rd_row} + 4'd1) == rd_vmax);
		end else begin
			rd_last = col_end;
		end
		raddr = addr_of(rd_row, rd_col);
	end

	// write port and valid-flag clears
	always_comb begin
		we    = 1'b0;
		waddr = addr_of(a_q, b_q);
		clr   = '0;
		case (state_q)
			S_EDGE: begin
				if (op_q == OP_INS) begin
					we = (w_q != '0) && !nz;
				end else if (nz) begin
					clr[addr_of(a_q, b_q)] = 1'b1;
					clr[addr_of(b_q, a_q)] = 1'b1;
				end
			end
			S_WR2: begin
				we    = 1'b1;
				waddr = addr_of(b_q, a_q);
			end
			S_DELV: begin
				if (rd_vld_s1 && rd_last_s1) begin
					for (int i = 0; i < NODES; i++) begin
						if (i < int'(v_q)) begin
							clr[addr_of(a_q, 3'(i))] = 1'b1;
							clr[addr_of(3'(i), a_q)] = 1'b1;
						end
					end
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= w_q;
		end
		rdata_s1  <= mem[raddr];
		rvalid_s1 <= valid_q[raddr];
	end

	// an entry that was never written, or was cleared, reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (valid_q & ~clr) | (DEPTH'(we) << waddr);
		end
	end

	// result selection
	always_comb begin
		em_en     = 1'b0;
		em_row    = 3'd0;
		em_col    = 3'd0;
		em_status = STAT_DONE;
		em_last   = 1'b1;
		em_total  = ecount_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_in)
						OP_FIND: begin
							em_en     = (v_in == 4'd0);
							em_status = STAT_NOMATCH;
						end
						OP_VDEL: begin
							em_en     = a_oor;
							em_status = STAT_RANGE;
						end
						default: begin
							em_en     = a_oor || b_oor;
							em_status = STAT_RANGE;
						end
					endcase
				end
			end
			S_EDGE: begin
				em_en = 1'b1;
				if (op_q == OP_INS) begin
					if (w_q == '0 || nz) begin
						em_status = STAT_NOCHG;
					end else begin
						em_total = ecount_q + 6'd1;
					end
				end else if (!nz) begin
					em_status = STAT_NOCHG;
				end else begin
					em_total = (ecount_q != 6'd0) ? ecount_q - 6'd1 : 6'd0;
				end
			end
			S_DELV: begin
				em_en     = rd_vld_s1 && rd_last_s1;
				em_total  = (ecount_q >= {2'd0, removed}) ? ecount_q - {2'd0, removed} : 6'd0;
				em_status = (removed != 4'd0) ? STAT_DONE : STAT_NOCHG;
			end
			S_SRCH: begin
				if (rd_vld_s1) begin
					if (hit && pend_q) begin
						// a newer match exists, so the held one is not the last
						em_en   = 1'b1;
						em_row  = prow_q;
						em_col  = pcol_q;
						em_last = 1'b0;
					end else if (rd_last_s1 && !hit) begin
						em_en = 1'b1;
						if (pend_q) begin
							em_row = prow_q;
							em_col = pcol_q;
						end else begin
							em_status = STAT_NOMATCH;
						end
					end
				end
			end
			S_FLUSH: begin
				em_en  = 1'b1;
				em_row = prow_q;
				em_col = pcol_q;
			end
			default: begin
				em_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rd_last_s1 <= rd_last;
		rd_row_s1  <= rd_row;
		rd_col_s1  <= rd_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ecount_q  <= 6'd0;
			strobe_q  <= 1'b0;
			issuing_q <= 1'b0;
			pend_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			cnt_q     <= 4'd0;
		end else begin
			rd_vld_s1 <= rd_en;
			strobe_q  <= em_en;
			if (em_en) begin
				row_q    <= em_row;
				col_q    <= em_col;
				status_q <= em_status;
				last_q   <= em_last;
				total_q  <= em_total;
				ecount_q <= em_total;
			end
			if (rd_en) begin
				c_q       <= col_end ? 3'd0 : rd_col + 3'd1;
				r_q       <= col_end ? rd_row + 3'd1 : rd_row;
				issuing_q <= !rd_last;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= op_in;
						a_q    <= vertex_a;
						b_q    <= vertex_b;
						w_q    <= w_in;
						v_q    <= v_in;
						cnt_q  <= 4'd0;
						pend_q <= 1'b0;
						if (rd_en) begin
							case (op_in)
								OP_FIND: state_q <= S_SRCH;
								OP_VDEL: state_q <= S_DELV;
								default: state_q <= S_EDGE;
							endcase
						end
					end
				end
				S_EDGE: begin
					if (op_q == OP_INS && w_q != '0 && !nz && a_q != b_q) begin
						state_q <= S_WR2;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_WR2: begin
					state_q <= S_IDLE;
				end
				S_DELV: begin
					if (rd_vld_s1) begin
						cnt_q <= removed;
						if (rd_last_s1) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SRCH: begin
					if (rd_vld_s1) begin
						if (hit) begin
							pend_q <= 1'b1;
							prow_q <= rd_row_s1;
							pcol_q <= rd_col_s1;
						end
						if (rd_last_s1) begin
							state_q <= hit ? S_FLUSH : S_IDLE;
						end
					end
				end
				S_FLUSH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe     = strobe_q;
	assign match_row  = row_q;
	assign match_col  = col_q;
	assign edge_total = total_q;
	assign status     = status_q;
	assign last       = last_q;

	// only a search run emits a beat that is not the last
	a_notlast_search: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |-> op_q == OP_FIND)
		else $error("non-final beat outside a search");

	// a write and a valid-flag clear never share a cycle
	a_no_wr_clr: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && (clr != '0)))
		else $error("write collides with clear");

	// an edge command always has its read data in the cycle after it is taken
	a_edge_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EDGE |-> rd_vld_s1)
		else $error("edge state without read data");

	// the block goes idle only around a result beat
	a_idle_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe_q || $past(strobe_q))
		else $error("run ended without a result");

	// scan reads stay inside the in-use square
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && state_q != S_IDLE |-> {1'b0, rd_col} < v_q && {1'b0, rd_row} < v_q)
		else $error("scan read out of range");

endmodule
